FILE: design/a2i_pkg.sv
// ----------------------------------------------------------------------------
// a2i_pkg
// Shared types, codes and character helpers for the ASCII integer parser.
// ----------------------------------------------------------------------------
package a2i_pkg;

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_SIGNED,
        PH_ZERO,
        PH_X,
        PH_DIGITS
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_NONE  = 2'd2
    } status_t;

    localparam int BASE_BITS = 6;
    localparam int DATA_BITS = 32;
    localparam int ADDR_BITS = 2;

    localparam logic [ADDR_BITS-1:0] ADDR_RADIX = 2'd0;

    localparam logic [BASE_BITS-1:0] NOT_DIGIT   = 6'd63;
    localparam logic [BASE_BITS-1:0] BASE_AUTO   = 6'd0;
    localparam logic [BASE_BITS-1:0] BASE_MIN    = 6'd2;
    localparam logic [BASE_BITS-1:0] BASE_OCT    = 6'd8;
    localparam logic [BASE_BITS-1:0] BASE_DEC    = 6'd10;
    localparam logic [BASE_BITS-1:0] BASE_HEX    = 6'd16;
    localparam logic [BASE_BITS-1:0] BASE_MAX    = 6'd36;
    localparam logic [BASE_BITS-1:0] RADIX_RESET = 6'd10;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    // digit value 0..35, NOT_DIGIT otherwise
    function automatic logic [BASE_BITS-1:0] digit_of(input logic [7:0] c);
        logic [7:0] t;
        t = {2'b00, NOT_DIGIT};
        if (c >= CH_0 && c <= CH_9)
        begin
            t = c - CH_0;
        end
        else if (c >= CH_UA && c <= CH_UZ)
        begin
            t = c - CH_UA + 8'd10;
        end
        else if (c >= CH_LA && c <= CH_LZ)
        begin
            t = c - CH_LA + 8'd10;
        end
        return t[BASE_BITS-1:0];
    endfunction

endpackage

FILE: design/a2i_acc.sv
// ----------------------------------------------------------------------------
// a2i_acc
// Digit accumulate: magnitude * base + digit with signed-limit range test.
// ----------------------------------------------------------------------------
module a2i_acc #(
    parameter int VALUE_BITS = 32
) (
    input  logic [VALUE_BITS-1:0]          magnitude,
    input  logic [a2i_pkg::BASE_BITS-1:0]  base,
    input  logic [a2i_pkg::BASE_BITS-1:0]  digit,
    input  logic                           negative,
    output logic [VALUE_BITS-1:0]          sum,
    output logic                           over
);
    import a2i_pkg::*;

    localparam int PW = VALUE_BITS + BASE_BITS + 1;

    logic [PW-1:0] prod;
    logic [PW-1:0] lim;

    // digit < base, so prod > lim is the cutoff/cutlim test
    assign prod = PW'(magnitude) * PW'(base) + PW'(digit);
    assign lim  = (PW'(1) << (VALUE_BITS - 1)) - (negative ? PW'(0) : PW'(1));
    assign over = prod > lim;
    assign sum  = prod[VALUE_BITS-1:0];

endmodule

FILE: design/ascii_to_signed_integer_parser.sv
// ----------------------------------------------------------------------------
// ascii_to_signed_integer_parser
// Streaming strtol-style parser: one character per request, one result per
// number (value, status, consumed).
// ----------------------------------------------------------------------------
//  channel | signals                                  | dir
//  --------+------------------------------------------+-----
//  in      | in_valid, in_ready, char_in              | in
//  out     | out_valid, out_ready, value, status,     | out
//          | consumed                                 |
//  cfg     | psel, penable, pwrite, paddr, pwdata,    | in
//          | prdata, pready (radix at 0x0)            |
//
//  One character per cycle while no result waits; a result is registered
//  as the ending character leaves the input register, which feeds one
//  multiply-add and range compare into the state and result registers.
//  Reset returns radix to 10 and the parser to whitespace skipping.
//  The input register holds while a result waits in the output register.
// ----------------------------------------------------------------------------
module ascii_to_signed_integer_parser #(
    parameter int VALUE_BITS = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [a2i_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [a2i_pkg::DATA_BITS-1:0]  pwdata,
    output logic [a2i_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     char_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [VALUE_BITS-1:0]   value,
    output logic [1:0]                     status,
    output logic [COUNT_BITS-1:0]          consumed
);
    import a2i_pkg::*;

    logic [BASE_BITS-1:0]  radix_reg;

    logic                  s1_valid_reg;
    logic [7:0]            char_reg;
    logic                  proceed;

    phase_t                phase_reg, phase_next;
    logic                  negative_reg, negative_next;
    logic [VALUE_BITS-1:0] magnitude_reg, magnitude_next;
    logic                  seen_reg, seen_next;
    logic                  ovf_reg, ovf_next;
    logic [BASE_BITS-1:0]  base_reg, base_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    status_t               status_reg, status_next;
    logic [COUNT_BITS-1:0] consumed_reg, consumed_next;

    logic                  emit;
    logic                  is_space;
    logic                  is_sign;
    logic                  is_x;
    logic                  zero_prefix;
    logic                  base_bad;
    logic                  digit_ok;
    logic [BASE_BITS-1:0]  dig;
    logic [BASE_BITS-1:0]  first_base;
    logic [BASE_BITS-1:0]  step_base;
    logic [COUNT_BITS:0]   count_sum;
    logic [COUNT_BITS-1:0] count_inc;
    logic [VALUE_BITS-1:0] acc_sum;
    logic                  acc_over;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_RADIX)
                  ? {{(DATA_BITS-BASE_BITS){1'b0}}, radix_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr == ADDR_RADIX)
        begin
            radix_reg <= pwdata[BASE_BITS-1:0];
        end
    end

    // input register
    assign proceed  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || proceed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (proceed)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= char_in;
        end
    end

    // character decode
    assign dig         = digit_of(char_reg);
    assign is_space    = (char_reg == CH_SPACE) || (char_reg >= CH_TAB && char_reg <= CH_CR);
    assign is_sign     = (char_reg == CH_PLUS) || (char_reg == CH_MINUS);
    assign is_x        = (char_reg == CH_LX) || (char_reg == CH_UX);
    assign zero_prefix = (radix_reg == BASE_AUTO || radix_reg == BASE_HEX)
                         && (char_reg == CH_0);
    assign first_base  = (radix_reg == BASE_AUTO) ? BASE_DEC : radix_reg;
    assign base_bad    = (first_base < BASE_MIN) || (first_base > BASE_MAX);

    always_comb
    begin
        unique case (phase_reg)
            PH_SKIP, PH_SIGNED: step_base = first_base;
            PH_ZERO:            step_base = (base_reg == BASE_HEX) ? BASE_HEX : BASE_OCT;
            PH_X:               step_base = BASE_HEX;
            PH_DIGITS:          step_base = base_reg;
            default:            step_base = base_reg;
        endcase
    end

    assign digit_ok = dig < step_base;

    assign count_sum = {1'b0, count_reg}
                     + ((phase_reg == PH_X) ? (COUNT_BITS+1)'(2) : (COUNT_BITS+1)'(1));
    assign count_inc = count_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}}
                                             : count_sum[COUNT_BITS-1:0];

    a2i_acc #(
        .VALUE_BITS (VALUE_BITS)
    ) u_acc (
        .magnitude (magnitude_reg),
        .base      (step_base),
        .digit     (dig),
        .negative  (negative_reg),
        .sum       (acc_sum),
        .over      (acc_over)
    );

    // end-of-number decision and result
    always_comb
    begin
        unique case (phase_reg)
            PH_SKIP:   emit = !is_space && !is_sign && !zero_prefix
                              && (base_bad || !digit_ok);
            PH_SIGNED: emit = !zero_prefix && (base_bad || !digit_ok);
            PH_ZERO:   emit = !is_x && !digit_ok;
            PH_X:      emit = !digit_ok;
            PH_DIGITS: emit = !digit_ok;
            default:   emit = 1'b0;
        endcase

        if (ovf_reg)
        begin
            value_next    = negative_reg ? {1'b1, {(VALUE_BITS-1){1'b0}}}
                                         : {1'b0, {(VALUE_BITS-1){1'b1}}};
            status_next   = ST_RANGE;
            consumed_next = count_reg;
        end
        else if (!seen_reg)
        begin
            value_next    = '0;
            status_next   = ST_NONE;
            consumed_next = '0;
        end
        else
        begin
            value_next    = negative_reg ? (~magnitude_reg + VALUE_BITS'(1)) : magnitude_reg;
            status_next   = ST_OK;
            consumed_next = count_reg;
        end
    end

    // parse state next value
    always_comb
    begin
        phase_next     = phase_reg;
        negative_next  = negative_reg;
        magnitude_next = magnitude_reg;
        seen_next      = seen_reg;
        ovf_next       = ovf_reg;
        base_next      = base_reg;
        count_next     = count_reg;

        if (emit)
        begin
            phase_next     = PH_SKIP;
            negative_next  = 1'b0;
            magnitude_next = '0;
            seen_next      = 1'b0;
            ovf_next       = 1'b0;
            base_next      = '0;
            count_next     = '0;
        end
        else if (phase_reg == PH_SKIP && is_space)
        begin
            count_next = count_inc;
        end
        else if (phase_reg == PH_SKIP && is_sign)
        begin
            negative_next = (char_reg == CH_MINUS);
            count_next    = count_inc;
            phase_next    = PH_SIGNED;
        end
        else if ((phase_reg == PH_SKIP || phase_reg == PH_SIGNED) && zero_prefix)
        begin
            base_next      = radix_reg;
            seen_next      = 1'b1;
            magnitude_next = '0;
            count_next     = count_inc;
            phase_next     = PH_ZERO;
        end
        else if (phase_reg == PH_ZERO && is_x)
        begin
            phase_next = PH_X;
        end
        else
        begin
            // digit taken in step_base
            base_next  = step_base;
            seen_next  = 1'b1;
            count_next = count_inc;
            phase_next = PH_DIGITS;
            if (ovf_reg || acc_over)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                magnitude_next = acc_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SKIP;
            negative_reg  <= 1'b0;
            magnitude_reg <= '0;
            seen_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            base_reg      <= '0;
            count_reg     <= '0;
        end
        else if (proceed)
        begin
            phase_reg     <= phase_next;
            negative_reg  <= negative_next;
            magnitude_reg <= magnitude_next;
            seen_reg      <= seen_next;
            ovf_reg       <= ovf_next;
            base_reg      <= base_next;
            count_reg     <= count_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proceed && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proceed && emit)
        begin
            value_reg    <= value_next;
            status_reg   <= status_next;
            consumed_reg <= consumed_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;
    assign consumed  = consumed_reg;

    // checks
    a_none_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_NONE |-> value == '0 && consumed == '0)
        else $error("no-conversion result carries data");

    a_conv_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_NONE |-> consumed != '0)
        else $error("conversion with zero characters consumed");

    a_range_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_RANGE |->
        value == {1'b1, {(VALUE_BITS-1){1'b0}}} || value == {1'b0, {(VALUE_BITS-1){1'b1}}})
        else $error("overflow result not saturated");

    a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !proceed |=> s1_valid_reg && $stable(char_reg))
        else $error("stalled character lost");

endmodule
